// File: src/brcp_pkg.sv
// Shared types, constants and helpers for the binary recurrent character predictor.
// No dependencies; imported by every module of the block.
package brcp_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int WORD_BITS    = 64;
    localparam int INDEX_W      = 13;
    localparam int SYMBOL_W     = 8;
    localparam int BEST_DOT_W   = 11;
    localparam int BEST_DOT_MAX = 1023;
    localparam int BEST_DOT_MIN = -1024;
    localparam int ARGMAX_START = -128;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_STEP  = 2'd2
    } kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write;
        logic clear;
        logic start;
        logic issue;
        logic issue_last;
        logic commit;
    } dp_cmd_t;

    function automatic logic [6:0] popcount64(input logic [WORD_BITS-1:0] x);
        logic [6:0] c;
        c = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            c = c + 7'(x[i]);
        end
        return c;
    endfunction

endpackage

// File: src/brcp_ctrl.sv
// Controller of the predictor: item acceptance, neuron address sequencing and
// output handshake. Depends on brcp_pkg.
module brcp_ctrl
    import brcp_pkg::*;
#(
    parameter int LAYER_BITS = 512
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    in_kind,
    output logic                          out_valid,
    input  logic                          out_ready,
    output dp_cmd_t                       cmd,
    output logic [$clog2(LAYER_BITS)-1:0] rd_addr,
    input  logic                          last_done
);

    localparam int ROW_AW = $clog2(LAYER_BITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t              state_reg;
    logic [ROW_AW-1:0]   cnt_reg;
    logic                out_valid_reg;
    logic                accept;
    kind_t               kind;

    assign kind      = kind_t'(in_kind);
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign rd_addr   = cnt_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.write      = accept && (kind == KIND_WRITE);
        cmd.clear      = accept && (kind == KIND_CLEAR);
        cmd.start      = accept && (kind == KIND_STEP);
        cmd.issue      = (state_reg == ST_RUN);
        cmd.issue_last = (state_reg == ST_RUN) && (cnt_reg == ROW_AW'(LAYER_BITS - 1));
        cmd.commit     = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (cmd.start)
                    begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cmd.issue_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (last_done)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (cmd.commit)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: src/brcp_datapath.sv
// Datapath of the predictor: banked weight memory, hidden state, popcount and
// dot pipeline, argmax and result registers. Depends on brcp_pkg.
module brcp_datapath
    import brcp_pkg::*;
#(
    parameter int LAYER_BITS = 512
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  dp_cmd_t                       cmd,
    input  logic [$clog2(LAYER_BITS)-1:0] rd_addr,
    input  logic [INDEX_W-1:0]            in_index,
    input  logic [WORD_BITS-1:0]          in_word,
    input  logic signed [SYMBOL_W-1:0]    in_symbol,
    output logic                          last_done,
    output logic signed [SYMBOL_W-1:0]    next_symbol,
    output logic signed [BEST_DOT_W-1:0]  best_dot
);

    // LAYER_BITS is a power of two, so a weight address splits into a row
    // (the neuron) and a bank (the word within the row pair).
    localparam int ROW_WORDS = LAYER_BITS / WORD_BITS;
    localparam int BANKS     = 2 * ROW_WORDS;
    localparam int BANK_W    = $clog2(BANKS);
    localparam int ROW_AW    = $clog2(LAYER_BITS);
    localparam int WADDR_W   = ROW_AW + BANK_W;
    localparam int EXT_W     = (WADDR_W > INDEX_W) ? WADDR_W : INDEX_W;
    localparam int DOT_W     = $clog2(LAYER_BITS + 1) + 1;

    logic [EXT_W-1:0]          wr_ext;
    logic                      wr_ok;
    logic [BANK_W-1:0]         wr_bank;
    logic [ROW_AW-1:0]         wr_row;

    logic [WORD_BITS-1:0]      rdata_reg [BANKS];
    logic [LAYER_BITS-1:0]     hidden_reg;
    logic [LAYER_BITS-1:0]     new_hidden_reg;
    logic signed [7:0]         diff_reg [ROW_WORDS];
    logic signed [DOT_W-1:0]   dot_sum;
    logic signed [DOT_W-1:0]   dot_reg;
    logic signed [DOT_W-1:0]   best_val_reg;
    logic [SYMBOL_W-1:0]       best_idx_reg;
    logic [ROW_AW-1:0]         nidx_reg;
    logic                      v1_reg, v2_reg, v3_reg;
    logic                      l1_reg, l2_reg, l3_reg;
    logic [SYMBOL_W-1:0]       sym_idx;
    logic signed [31:0]        best_ext;
    logic signed [BEST_DOT_W-1:0] best_sat;
    logic signed [SYMBOL_W-1:0] next_symbol_reg;
    logic signed [BEST_DOT_W-1:0] best_dot_reg;

    assign wr_ext  = EXT_W'(in_index);
    assign wr_ok   = (wr_ext >> WADDR_W) == '0;
    assign wr_bank = wr_ext[BANK_W-1:0];
    assign wr_row  = wr_ext[WADDR_W-1:BANK_W];

    // Banks below ROW_WORDS hold the positive row, the rest the negative row.
    for (genvar b = 0; b < BANKS; b++)
    begin : g_bank
        logic [WORD_BITS-1:0] mem [LAYER_BITS];

        always_ff @(posedge clk)
        begin
            if (cmd.write && wr_ok && (wr_bank == BANK_W'(b)))
            begin
                mem[wr_row] <= in_word;
            end
            if (cmd.issue)
            begin
                rdata_reg[b] <= mem[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int w = 0; w < ROW_WORDS; w++)
        begin
            diff_reg[w] <= $signed({1'b0, popcount64(rdata_reg[w]
                                        & hidden_reg[w*WORD_BITS +: WORD_BITS])})
                         - $signed({1'b0, popcount64(rdata_reg[ROW_WORDS + w]
                                        & hidden_reg[w*WORD_BITS +: WORD_BITS])});
        end
        dot_reg <= dot_sum;
    end

    always_comb
    begin
        dot_sum = '0;
        for (int w = 0; w < ROW_WORDS; w++)
        begin
            dot_sum = dot_sum + DOT_W'(diff_reg[w]);
        end
    end

    assign sym_idx   = in_symbol ^ 8'h80;
    assign last_done = v3_reg && l3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            l1_reg     <= 1'b0;
            l2_reg     <= 1'b0;
            l3_reg     <= 1'b0;
            hidden_reg <= '0;
            nidx_reg   <= '0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            l1_reg <= cmd.issue_last;
            v2_reg <= v1_reg;
            l2_reg <= l1_reg;
            v3_reg <= v2_reg;
            l3_reg <= l2_reg;

            if (cmd.clear)
            begin
                hidden_reg <= '0;
            end
            else if (cmd.start)
            begin
                hidden_reg[SYMBOL_COUNT-1:0] <= SYMBOL_COUNT'(1) << sym_idx;
            end
            else if (cmd.commit)
            begin
                hidden_reg <= new_hidden_reg;
            end

            if (cmd.start)
            begin
                nidx_reg <= '0;
            end
            else if (v3_reg)
            begin
                nidx_reg <= nidx_reg + 1'b1;
            end
        end
    end

    // Neuron results arrive in index order; each new state bit shifts in at
    // the top so that bit o lands at position o after the last neuron.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            best_val_reg <= DOT_W'(ARGMAX_START);
            best_idx_reg <= '0;
        end
        else if (v3_reg)
        begin
            new_hidden_reg <= {(!dot_reg[DOT_W-1] && (dot_reg != '0)),
                               new_hidden_reg[LAYER_BITS-1:1]};
            if (({1'b0, nidx_reg} < (ROW_AW + 1)'(SYMBOL_COUNT)) && (dot_reg > best_val_reg))
            begin
                best_val_reg <= dot_reg;
                best_idx_reg <= nidx_reg[SYMBOL_W-1:0];
            end
        end
    end

    assign best_ext = 32'(best_val_reg);

    always_comb
    begin
        if (best_ext > 32'(BEST_DOT_MAX))
        begin
            best_sat = BEST_DOT_W'(BEST_DOT_MAX);
        end
        else if (best_ext < 32'(BEST_DOT_MIN))
        begin
            best_sat = BEST_DOT_W'(BEST_DOT_MIN);
        end
        else
        begin
            best_sat = best_ext[BEST_DOT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            next_symbol_reg <= best_idx_reg ^ 8'h80;
            best_dot_reg    <= best_sat;
        end
    end

    assign next_symbol = next_symbol_reg;
    assign best_dot    = best_dot_reg;

endmodule

// File: src/binary_recurrent_char_predictor.sv
// Top level of the binary recurrent character predictor: stream ports around
// the controller and datapath. Depends on brcp_pkg, brcp_ctrl, brcp_datapath.
// Weight writes and clears are accepted back to back.
// A step reads one row pair per cycle from the banked weight memory; the read
// words, the per-word differences and the dot product are registered before
// the argmax, and the result register loads once the output is free. The next
// item is accepted in the same cycle that the result appears. Asynchronous active-low
// reset clears the hidden state and control; weights are undefined until written.
module binary_recurrent_char_predictor
    import brcp_pkg::*;
#(
    parameter int LAYER_BITS = 512
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,   // weight_index[12:0], weight_word[76:13], symbol[84:77]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // next_symbol[7:0], best_dot[18:8]
);

    dp_cmd_t                       cmd;
    logic [$clog2(LAYER_BITS)-1:0] rd_addr;
    logic                          last_done;
    logic signed [SYMBOL_W-1:0]    next_symbol;
    logic signed [BEST_DOT_W-1:0]  best_dot;

    brcp_ctrl #(
        .LAYER_BITS (LAYER_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_kind   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .last_done (last_done)
    );

    brcp_datapath #(
        .LAYER_BITS (LAYER_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .in_index    (s_axis_tdata[12:0]),
        .in_word     (s_axis_tdata[76:13]),
        .in_symbol   (s_axis_tdata[84:77]),
        .last_done   (last_done),
        .next_symbol (next_symbol),
        .best_dot    (best_dot)
    );

    assign m_axis_tdata = {5'b0, best_dot, next_symbol};

endmodule

// File: src/brcp_checker.sv
// Port-level assertions for the binary recurrent character predictor, bound
// to the top level. Depends on brcp_pkg and binary_recurrent_char_predictor.
module brcp_checker
    import brcp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    logic take;

    assign take = s_axis_tvalid && s_axis_tready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // Writes and clears finish in the cycle they are taken.
    a_short_items: assert property (@(posedge clk) disable iff (!rst_n)
        take && (s_axis_tuser == KIND_WRITE || s_axis_tuser == KIND_CLEAR)
        |=> s_axis_tready)
        else $error("input stalled after a write or clear word");

    // A step occupies the block until its result is committed.
    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        take && (s_axis_tuser == KIND_STEP) |=> !s_axis_tready)
        else $error("input accepted during a step");

endmodule

bind binary_recurrent_char_predictor brcp_checker u_brcp_checker (.*);
